@@ hdl/tli_pkg.sv @@
// ----------------------------------------------------------------------------
// tli_pkg
// Shared sizes, row field layout and pipeline types of the table linear
// interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int ROW_SLOTS     = 8;
	localparam int SLOT_W        = $clog2(ROW_SLOTS);
	localparam int CFG_IDX_W     = SLOT_W + 1;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int POS_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int SEARCH_STEPS  = POS_W;

	localparam int DATA_W = 16;
	localparam int ROW_W  = 64;
	localparam int LANES  = 3;

	localparam int NUM_W     = 2 * DATA_W;
	localparam int DEN_W     = DATA_W;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;

	typedef logic [ROW_SLOTS-1:0][ROW_W-1:0] table_t;

	typedef enum logic [1:0] {
		REGION_LOW    = 2'd0,
		REGION_INSIDE = 2'd1,
		REGION_HIGH   = 2'd2
	} region_t;

	typedef struct packed {
		logic    valid;
		region_t region;
		logic    bypass;
	} ctl_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] key;
		logic [POS_W-1:0]  pos;
	} search_t;

	typedef struct packed {
		logic [DEN_W-1:0]  rem;
		logic [NUM_W-1:0]  nq;
		logic              neg;
		logic [DATA_W-1:0] lo_v;
	} dlane_t;

	typedef struct packed {
		ctl_t                  ctl;
		logic [DEN_W-1:0]      den;
		dlane_t [LANES-1:0]    lane;
	} dstage_t;

	function automatic logic [DATA_W-1:0] bp_of(logic [ROW_W-1:0] row);
		return row[ROW_W-DATA_W +: DATA_W];
	endfunction

	function automatic logic [DATA_W-1:0] val_of(logic [ROW_W-1:0] row, int l);
		return row[ROW_W-DATA_W*(l+2) +: DATA_W];
	endfunction

endpackage

@@ hdl/tli_search.sv @@
// ----------------------------------------------------------------------------
// tli_search
// Breakpoint compare stage and binary search stage, giving the insert
// position of each key.
// ----------------------------------------------------------------------------
module tli_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [tli_pkg::DATA_W-1:0]    in_key,
	input  tli_pkg::table_t               tbl,
	output tli_pkg::search_t              out
);

	logic                                 valid_s1;
	logic [tli_pkg::DATA_W-1:0]           key_s1;
	logic [tli_pkg::TABLE_ENTRIES-1:0]    lt_s1;
	logic [tli_pkg::TABLE_ENTRIES-1:0]    eq_s1;
	logic [tli_pkg::POS_W-1:0]            pos_d;
	tli_pkg::search_t                     res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= in_key;
		for (int i = 0; i < tli_pkg::TABLE_ENTRIES; i++) begin
			lt_s1[i] <= tli_pkg::bp_of(tbl[i]) < in_key;
			eq_s1[i] <= tli_pkg::bp_of(tbl[i]) == in_key;
		end
	end

	// insert-position search with early stop on an equal breakpoint
	always_comb begin
		logic [tli_pkg::POS_W-1:0] left;
		logic [tli_pkg::POS_W-1:0] right;
		logic [tli_pkg::POS_W:0]   sum;
		logic [tli_pkg::IDX_W-1:0] mid;
		logic [tli_pkg::IDX_W-1:0] hit;
		logic                      found;
		left  = '0;
		right = tli_pkg::POS_W'(tli_pkg::TABLE_ENTRIES);
		sum   = '0;
		mid   = '0;
		hit   = '0;
		found = 1'b0;
		for (int s = 0; s < tli_pkg::SEARCH_STEPS; s++) begin
			if (!found && (left < right)) begin
				sum = {1'b0, left} + {1'b0, right};
				mid = sum[tli_pkg::IDX_W:1];
				if (eq_s1[mid]) begin
					found = 1'b1;
					hit   = mid;
				end else if (lt_s1[mid]) begin
					left = tli_pkg::POS_W'(mid) + tli_pkg::POS_W'(1);
				end else begin
					right = tli_pkg::POS_W'(mid);
				end
			end
		end
		pos_d = found ? tli_pkg::POS_W'(hit) : left;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else begin
			res_s2.valid <= valid_s1;
			res_s2.key   <= key_s1;
			res_s2.pos   <= pos_d;
		end
	end

	assign out = res_s2;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_s2.valid |-> res_s2.pos <= tli_pkg::POS_W'(tli_pkg::TABLE_ENTRIES))
		else $error("insert position past table end");

endmodule

@@ hdl/tli_prep.sv @@
// ----------------------------------------------------------------------------
// tli_prep
// Row select, differences, products and sign/magnitude split ahead of the
// divider.
// ----------------------------------------------------------------------------
module tli_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  tli_pkg::search_t  in,
	input  tli_pkg::table_t   tbl,
	output tli_pkg::dstage_t  out
);

	localparam logic [tli_pkg::POS_W-1:0] LAST_POS =
		tli_pkg::POS_W'(tli_pkg::TABLE_ENTRIES);
	localparam logic [tli_pkg::IDX_W-1:0] LAST_IDX =
		tli_pkg::IDX_W'(tli_pkg::TABLE_ENTRIES - 1);

	logic [tli_pkg::IDX_W-1:0]  lo_idx;
	logic [tli_pkg::IDX_W-1:0]  hi_idx;
	logic [tli_pkg::ROW_W-1:0]  lo_row;
	logic [tli_pkg::ROW_W-1:0]  hi_row;
	tli_pkg::region_t           region_d;
	logic signed [16:0]         span_d;

	tli_pkg::ctl_t                     ctl_s3;
	logic signed [16:0]                dk_s3;
	logic [tli_pkg::DEN_W-1:0]         den_s3;
	logic                              sneg_s3;
	logic signed [16:0]                dv_s3   [tli_pkg::LANES];
	logic [tli_pkg::DATA_W-1:0]        lo_v_s3 [tli_pkg::LANES];

	tli_pkg::ctl_t                     ctl_s4;
	logic [tli_pkg::DEN_W-1:0]         den_s4;
	logic                              sneg_s4;
	logic signed [33:0]                prod_s4 [tli_pkg::LANES];
	logic [tli_pkg::DATA_W-1:0]        lo_v_s4 [tli_pkg::LANES];

	tli_pkg::dstage_t                  res_s5;

	always_comb begin
		if (in.pos == '0) begin
			region_d = tli_pkg::REGION_LOW;
			lo_idx   = '0;
			hi_idx   = '0;
		end else if (in.pos >= LAST_POS) begin
			region_d = tli_pkg::REGION_HIGH;
			lo_idx   = LAST_IDX;
			hi_idx   = LAST_IDX;
		end else begin
			region_d = tli_pkg::REGION_INSIDE;
			lo_idx   = tli_pkg::IDX_W'(in.pos - tli_pkg::POS_W'(1));
			hi_idx   = tli_pkg::IDX_W'(in.pos);
		end
		lo_row = tbl[tli_pkg::SLOT_W'(lo_idx)];
		hi_row = tbl[tli_pkg::SLOT_W'(hi_idx)];
		span_d = $signed({1'b0, tli_pkg::bp_of(hi_row)}) -
			$signed({1'b0, tli_pkg::bp_of(lo_row)});
	end

	// stage 3: row select and differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3.valid  <= in.valid;
			ctl_s3.region <= region_d;
			ctl_s3.bypass <= (region_d != tli_pkg::REGION_INSIDE) || (span_d == '0);
		end
	end

	always_ff @(posedge clk) begin
		dk_s3   <= $signed({1'b0, in.key}) - $signed({1'b0, tli_pkg::bp_of(lo_row)});
		den_s3  <= span_d[16] ? tli_pkg::DEN_W'(-span_d) : tli_pkg::DEN_W'(span_d);
		sneg_s3 <= span_d[16];
		for (int l = 0; l < tli_pkg::LANES; l++) begin
			dv_s3[l]   <= $signed({1'b0, tli_pkg::val_of(hi_row, l)}) -
				$signed({1'b0, tli_pkg::val_of(lo_row, l)});
			lo_v_s3[l] <= tli_pkg::val_of(lo_row, l);
		end
	end

	// stage 4: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		den_s4  <= den_s3;
		sneg_s4 <= sneg_s3;
		for (int l = 0; l < tli_pkg::LANES; l++) begin
			prod_s4[l] <= dv_s3[l] * dk_s3;
			lo_v_s4[l] <= lo_v_s3[l];
		end
	end

	// stage 5: sign and magnitude for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s5 <= '0;
		end else begin
			res_s5.ctl <= ctl_s4;
			res_s5.den <= den_s4;
			for (int l = 0; l < tli_pkg::LANES; l++) begin
				res_s5.lane[l].rem  <= '0;
				res_s5.lane[l].nq   <= prod_s4[l][33] ? tli_pkg::NUM_W'(-prod_s4[l]) :
					tli_pkg::NUM_W'(prod_s4[l]);
				res_s5.lane[l].neg  <= prod_s4[l][33] ^ sneg_s4;
				res_s5.lane[l].lo_v <= lo_v_s4[l];
			end
		end
	end

	assign out = res_s5;

endmodule

@@ hdl/tli_div.sv @@
// ----------------------------------------------------------------------------
// tli_div
// Pipelined restoring divider, three lanes sharing one divisor, four
// quotient bits per stage.
// ----------------------------------------------------------------------------
module tli_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tli_pkg::dstage_t  in,
	output tli_pkg::dstage_t  out
);

	tli_pkg::dstage_t pipe_s [tli_pkg::DIV_STAGES];

	function automatic tli_pkg::dlane_t div_step(tli_pkg::dlane_t l,
		logic [tli_pkg::DEN_W-1:0] den);
		tli_pkg::dlane_t           r;
		logic [tli_pkg::DEN_W:0]   part;
		r    = l;
		part = '0;
		for (int s = 0; s < tli_pkg::DIV_STEPS; s++) begin
			part = {r.rem, r.nq[tli_pkg::NUM_W-1]};
			r.nq = {r.nq[tli_pkg::NUM_W-2:0], 1'b0};
			if (part >= {1'b0, den}) begin
				part    = part - {1'b0, den};
				r.nq[0] = 1'b1;
			end
			r.rem = part[tli_pkg::DEN_W-1:0];
		end
		return r;
	endfunction

	function automatic tli_pkg::dstage_t stage_step(tli_pkg::dstage_t d);
		tli_pkg::dstage_t r;
		r = d;
		for (int l = 0; l < tli_pkg::LANES; l++) begin
			r.lane[l] = div_step(d.lane[l], d.den);
		end
		return r;
	endfunction

	function automatic logic rem_ok(tli_pkg::dstage_t d);
		logic ok;
		ok = 1'b1;
		for (int l = 0; l < tli_pkg::LANES; l++) begin
			ok = ok && (d.lane[l].rem < d.den);
		end
		return ok;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tli_pkg::DIV_STAGES; k++) begin
				pipe_s[k] <= '0;
			end
		end else begin
			pipe_s[0] <= stage_step(in);
			for (int k = 1; k < tli_pkg::DIV_STAGES; k++) begin
				pipe_s[k] <= stage_step(pipe_s[k-1]);
			end
		end
	end

	assign out = pipe_s[tli_pkg::DIV_STAGES-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out.ctl.valid && !out.ctl.bypass) |-> rem_ok(out))
		else $error("divider remainder not below divisor");

endmodule

@@ hdl/table_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear lookup of three value tables over eight shared Q8.8
// breakpoints, with clamping at both ends.
// ----------------------------------------------------------------------------
// One key is taken in every clock cycle and busy never rises. Each result
// shows on the result ports, marked by done for one cycle, after its key
// has passed the breakpoint compare and binary search stages, the row
// select, multiply and sign split stages, the divider stages at four
// quotient bits per stage, and one output register. The receiver
// cannot stall, so results must be taken as they come. Table rows are
// written on the cfg port and must only change while no key is in flight.
// ----------------------------------------------------------------------------
module table_linear_interpolator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [tli_pkg::DATA_W-1:0]       key,
	output logic                             done,
	output logic [tli_pkg::DATA_W-1:0]       value_a,
	output logic [tli_pkg::DATA_W-1:0]       value_b,
	output logic [tli_pkg::DATA_W-1:0]       value_c,
	output logic [1:0]                       region,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tli_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tli_pkg::ROW_W-1:0]        cfg_data
);

	localparam logic [tli_pkg::SLOT_W-1:0] LAST_SLOT =
		tli_pkg::SLOT_W'(tli_pkg::TABLE_ENTRIES - 1);

	tli_pkg::table_t            rows_q;
	tli_pkg::search_t           srch;
	tli_pkg::dstage_t           prep;
	tli_pkg::dstage_t           quot;
	logic [tli_pkg::DATA_W-1:0] val_d [tli_pkg::LANES];

	logic                       done_q;
	tli_pkg::region_t           region_q;
	logic [tli_pkg::DATA_W-1:0] val_q [tli_pkg::LANES];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// table rows, written one beat at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (cfg_valid && cfg_ready &&
			(cfg_index < tli_pkg::CFG_IDX_W'(tli_pkg::ROW_SLOTS))) begin
			rows_q[cfg_index[tli_pkg::SLOT_W-1:0]] <= cfg_data;
		end
	end

	tli_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_key   (key),
		.tbl      (rows_q),
		.out      (srch)
	);

	tli_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (srch),
		.tbl    (rows_q),
		.out    (prep)
	);

	tli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (prep),
		.out    (quot)
	);

	// apply quotient sign, add lower value, saturate; on bypass pass the lower value
	always_comb begin
		logic [tli_pkg::NUM_W+1:0] lo_x;
		logic [tli_pkg::NUM_W+1:0] q_x;
		logic [tli_pkg::NUM_W+1:0] sum;
		lo_x = '0;
		q_x  = '0;
		sum  = '0;
		for (int l = 0; l < tli_pkg::LANES; l++) begin
			lo_x = (tli_pkg::NUM_W+2)'(quot.lane[l].lo_v);
			q_x  = (tli_pkg::NUM_W+2)'(quot.lane[l].nq);
			sum  = quot.lane[l].neg ? (lo_x - q_x) : (lo_x + q_x);
			if (quot.ctl.bypass) begin
				val_d[l] = quot.lane[l].lo_v;
			end else if (sum[tli_pkg::NUM_W+1]) begin
				val_d[l] = '0;
			end else if (sum[tli_pkg::NUM_W:tli_pkg::DATA_W] != '0) begin
				val_d[l] = '1;
			end else begin
				val_d[l] = sum[tli_pkg::DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= quot.ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		region_q <= quot.ctl.region;
		for (int l = 0; l < tli_pkg::LANES; l++) begin
			val_q[l] <= val_d[l];
		end
	end

	assign done    = done_q;
	assign value_a = val_q[0];
	assign value_b = val_q[1];
	assign value_c = val_q[2];
	assign region  = region_q;

	a_low_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (region_q == tli_pkg::REGION_LOW)) |->
		(value_a == tli_pkg::val_of(rows_q[0], 0)) &&
		(value_c == tli_pkg::val_of(rows_q[0], 2)))
		else $error("low clamp does not return first row");

	a_high_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (region_q == tli_pkg::REGION_HIGH)) |->
		(value_a == tli_pkg::val_of(rows_q[LAST_SLOT], 0)) &&
		(value_b == tli_pkg::val_of(rows_q[LAST_SLOT], 1)))
		else $error("high clamp does not return last row");

endmodule
